// File: rtl/core/sida_pkg.sv
`default_nettype none

package sida_pkg;

  // width of the two's complement input value
  localparam int unsigned VALUE_BITS = 32;

  // decimal digits needed for the magnitude: floor(bits * log10(2)) + 1
  localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  // counter widths
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);
  localparam int unsigned REM_W = $clog2(NUM_DIGITS + 1);

  // character and digit widths
  localparam int unsigned CHAR_W  = 6;
  localparam int unsigned DIGIT_W = 4;

  // ascii codes, truncated to the character width
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
  localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

  // control word broadcast to every digit cell
  typedef struct packed {
    logic clear;      // load zero into the digit
    logic bit_shift;  // add-3 correction then shift one bit in
    logic dig_shift;  // take the digit of the lower neighbor
  } cell_ctrl_t;

  // add-3 correction of one bcd digit before a left shift
  function automatic logic [DIGIT_W-1:0] dd_adjust(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = (d >= DIGIT_W'(5)) ? d + DIGIT_W'(3) : d;
    return r;
  endfunction

  // bit that a digit hands to its upper neighbor on a shift
  function automatic logic dd_carry(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W-1:0] r;
    r = dd_adjust(d);
    return r[DIGIT_W-1];
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii_top.sv
`default_nettype none

// Converts one signed integer per item into its decimal ASCII text, one
// character per result on text_char_o with last_char_o marking the final
// character; a negative value starts with '-', zero gives a single '0'.
// An item is taken when start is high and busy is low. Results come
// out on strobe for one cycle each and cannot be held off, so the
// receiver must take one character in every cycle that strobe is high.
// A row of BCD digit cells builds the decimal form with one shift-and-add-3
// step per input bit, then leading zero digits are shifted out of the top
// cell one per cycle and the remaining digits are sent one per cycle. Every
// item occupies the block for the same time whatever its value, set by the
// bit loop and the digit shift of the cell row; the last character appears
// in the first cycle with busy low.
module signed_int_to_decimal_ascii_top (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [sida_pkg::VALUE_BITS-1:0]    value_i,
  output logic                                    strobe,
  output logic      [sida_pkg::CHAR_W-1:0]        text_char_o,
  output logic                                    last_char_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

  state_e                           state_q;
  logic [sida_pkg::VALUE_BITS-1:0]  mag_q;
  logic                             neg_q;
  logic [sida_pkg::CNT_W-1:0]       cnt_q;
  logic [sida_pkg::REM_W-1:0]       rem_q;
  logic                             strobe_q;
  logic [sida_pkg::CHAR_W-1:0]      char_q;
  logic                             last_q;

  logic                             accept;
  logic                             neg_in;
  logic [sida_pkg::VALUE_BITS-1:0]  mag_in;
  logic                             top_zero;
  logic                             skip_more;
  logic [sida_pkg::DIGIT_W-1:0]     top_digit;
  sida_pkg::cell_ctrl_t             ctrl;

  logic [sida_pkg::DIGIT_W-1:0]     digit [sida_pkg::NUM_DIGITS];
  logic                             carry [sida_pkg::NUM_DIGITS];

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  // magnitude in unsigned arithmetic, so the most negative value works
  assign neg_in = value_i[sida_pkg::VALUE_BITS-1];
  assign mag_in = neg_in ? ('0 - value_i) : value_i;

  assign top_digit = digit[sida_pkg::NUM_DIGITS-1];
  assign top_zero  = (top_digit == '0);
  assign skip_more = top_zero && (rem_q > sida_pkg::REM_W'(1));

  // control word for the cell row
  always_comb begin
    ctrl.clear     = accept;
    ctrl.bit_shift = (state_q == ST_CONV);
    ctrl.dig_shift = ((state_q == ST_SKIP) && skip_more) || (state_q == ST_EMIT);
  end

  // row of bcd digit cells, least significant at index 0
  for (genvar i = 0; i < sida_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign carry[i] = mag_q[sida_pkg::VALUE_BITS-1];
      sida_bcd_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .carry_i (carry[i]),
        .digit_i ('0),
        .digit_o (digit[i])
      );
    end else begin : g_rest
      assign carry[i] = sida_pkg::dd_carry(digit[i-1]);
      sida_bcd_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .carry_i (carry[i]),
        .digit_i (digit[i-1]),
        .digit_o (digit[i])
      );
    end
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      strobe_q <= 1'b0;
      neg_q    <= 1'b0;
      cnt_q    <= '0;
      rem_q    <= '0;
      mag_q    <= '0;
      char_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      strobe_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            mag_q   <= mag_in;
            neg_q   <= neg_in;
            cnt_q   <= sida_pkg::CNT_W'(sida_pkg::VALUE_BITS - 1);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q <= {mag_q[sida_pkg::VALUE_BITS-2:0], 1'b0};
          cnt_q <= cnt_q - sida_pkg::CNT_W'(1);
          if (cnt_q == '0) begin
            rem_q   <= sida_pkg::REM_W'(sida_pkg::NUM_DIGITS);
            state_q <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          if (skip_more) begin
            rem_q <= rem_q - sida_pkg::REM_W'(1);
          end else begin
            // sign goes out while the first digit waits in the top cell
            if (neg_q) begin
              strobe_q <= 1'b1;
              char_q   <= sida_pkg::ASCII_MINUS;
              last_q   <= 1'b0;
            end
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          strobe_q <= 1'b1;
          char_q   <= sida_pkg::ASCII_ZERO + sida_pkg::CHAR_W'(top_digit);
          last_q   <= (rem_q == sida_pkg::REM_W'(1));
          rem_q    <= rem_q - sida_pkg::REM_W'(1);
          if (rem_q == sida_pkg::REM_W'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign strobe      = strobe_q;
  assign text_char_o = char_q;
  assign last_char_o = last_q;

endmodule

`default_nettype wire

// File: rtl/core/sida_bcd_cell.sv
`default_nettype none

module sida_bcd_cell (
  input  wire logic                         clk_i,
  input  wire sida_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic                         carry_i,
  input  wire logic [sida_pkg::DIGIT_W-1:0] digit_i,
  output logic      [sida_pkg::DIGIT_W-1:0] digit_o
);

  logic [sida_pkg::DIGIT_W-1:0] digit_q;
  logic [sida_pkg::DIGIT_W-1:0] digit_d;
  logic [sida_pkg::DIGIT_W-1:0] adj;

  // shift-and-add-3 step or digit hand-over
  always_comb begin
    adj = sida_pkg::dd_adjust(digit_q);
    priority if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.bit_shift) begin
      digit_d = {adj[sida_pkg::DIGIT_W-2:0], carry_i};
    end else if (ctrl_i.dig_shift) begin
      digit_d = digit_i;
    end else begin
      digit_d = digit_q;
    end
  end

  // digit register
  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned VALUE_BITS   = sida_pkg::VALUE_BITS;
  localparam int unsigned CHAR_W       = sida_pkg::CHAR_W;
  localparam int unsigned DIGIT_W      = sida_pkg::DIGIT_W;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned TAIL_CYCLES  = 60;
  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned PRINT_LIMIT  = 40;

  // one expected character of a number's text
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_char_t;

  // expected text of every accepted value, oldest character first
  class char_scoreboard;
    text_char_t  pending_chars[$];
    int unsigned fails;

    function new();
      fails = 0;
    endfunction

    // decimal text of one accepted value, sign first, digits msd first
    function void note_value(logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] mag;
      logic [DIGIT_W-1:0]    digits[$];
      text_char_t            c;
      // magnitude in unsigned arithmetic, so the most negative value works
      mag = v[VALUE_BITS-1] ? (VALUE_BITS'(0) - v) : v;
      do begin
        digits.push_front(DIGIT_W'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (v[VALUE_BITS-1]) begin
        c.ch   = sida_pkg::ASCII_MINUS;
        c.last = 1'b0;
        pending_chars.push_back(c);
      end
      for (int i = 0; i < digits.size(); i++) begin
        c.ch   = sida_pkg::ASCII_ZERO + CHAR_W'(digits[i]);
        c.last = (i == digits.size() - 1);
        pending_chars.push_back(c);
      end
    endfunction

    task report(string what, int exp_v, int got_v);
      fails++;
      if (fails <= PRINT_LIMIT)
        $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, exp_v, got_v);
    endtask

    // compare one emitted character with the oldest expectation
    task check_char(logic [CHAR_W-1:0] ch, logic last);
      text_char_t c;
      if (pending_chars.size() == 0) begin
        report("unexpected character", -1, ch);
      end else begin
        c = pending_chars.pop_front();
        if (ch !== c.ch) report("text_char", c.ch, ch);
        if (last !== c.last) report("last_char", c.last, last);
      end
    endtask

    function int pending();
      return pending_chars.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [VALUE_BITS-1:0] value_i;
  logic                  strobe;
  logic [CHAR_W-1:0]     text_char_o;
  logic                  last_char_o;

  char_scoreboard sb = new();
  int unsigned    idle_cycles = 0;
  bit             quiet_stretch = 1'b0;

  signed_int_to_decimal_ascii_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .value_i     (value_i),
    .strobe      (strobe),
    .text_char_o (text_char_o),
    .last_char_o (last_char_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // monitor: check characters, note accepted items, track inactivity
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (strobe === 1'b1) sb.check_char(text_char_o, last_char_o);
      if (start && busy === 1'b0) sb.note_value(value_i);
      if (strobe === 1'b1 || (start && busy === 1'b0)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // gap before the next item: mostly short, a few long, none in quiet stretches
  function int unsigned next_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet_stretch) return 0;
    if (r < 60) return $urandom_range(2);
    if (r < 92) return $urandom_range(8, 3);
    return $urandom_range(70, 20);
  endfunction

  // random value: raw words, extremes, or a random digit count and sign
  function logic [VALUE_BITS-1:0] rand_value();
    int unsigned sel;
    int unsigned k;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    sel = $urandom_range(9);
    if (sel < 3) return $urandom();
    if (sel == 3) begin
      case ($urandom_range(4))
        0: return '0;
        1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
        2: return {1'b0, {(VALUE_BITS-1){1'b1}}};
        3: return '1;
        default: return VALUE_BITS'(1);
      endcase
    end
    k  = $urandom_range(10, 1);
    lo = 1;
    for (int i = 1; i < k; i++) lo = lo * 10;
    hi  = (k == 10) ? 32'h7FFF_FFFF : lo * 10 - 1;
    mag = $urandom_range(hi, lo);
    return $urandom_range(1) ? (VALUE_BITS'(0) - VALUE_BITS'(mag)) : VALUE_BITS'(mag);
  endfunction

  // offer one item after a gap and return at the edge that accepts it
  task send_value(logic [VALUE_BITS-1:0] v, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  // hold off the sender until every expected character has come
  task wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  logic [VALUE_BITS-1:0] directed_values[] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFF7,
    32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE, 32'd1000000000, 32'hC465_3600,
    32'd999999999, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1234567890, 32'd1000000,
    32'h0000_8000
  };

  // stimulus
  initial begin
    rst_ni  = 1'b0;
    start   = 1'b0;
    value_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, zero, sign and digit-count boundaries
    foreach (directed_values[i]) send_value(directed_values[i], next_gap());
    wait_drained();
    repeat (3) @(posedge clk_i);

    // random items, alternating idle and back-to-back stretches
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet_stretch = ((n / 32) % 3 == 2);
      if (n == RANDOM_ITEMS / 2) wait_drained();
      send_value(rand_value(), next_gap());
    end

    // drain and let the block settle
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
